// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is asserted.
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, also during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/svpwm_pkg.sv -----
// Package with the constants and types of the space vector PWM duty block.
`timescale 1ns / 1ps

package svpwm_pkg;

  // sqrt(3)/2 in unsigned Q0.15.
  localparam logic [14:0] SQRT3_HALF_Q15 = 15'd28378;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MAX = 2'd1;

  // Register reset values.
  localparam logic [15:0] DUTY_GAIN_RST   = 16'd16384;
  localparam logic [15:0] COMPARE_MAX_RST = 16'd5599;

  // Sign patterns {r3 > 0, r2 > 0, r1 > 0} of the three projections.
  localparam logic [2:0] SIGNS_S1 = 3'b011;
  localparam logic [2:0] SIGNS_S2 = 3'b001;
  localparam logic [2:0] SIGNS_S3 = 3'b101;
  localparam logic [2:0] SIGNS_S4 = 3'b100;
  localparam logic [2:0] SIGNS_S5 = 3'b110;
  localparam logic [2:0] SIGNS_S6 = 3'b010;

  // Sector codes as they appear on the output.
  typedef enum logic [2:0] {
    SECTOR_ZERO = 3'd0,
    SECTOR_1    = 3'd1,
    SECTOR_2    = 3'd2,
    SECTOR_3    = 3'd3,
    SECTOR_4    = 3'd4,
    SECTOR_5    = 3'd5,
    SECTOR_6    = 3'd6
  } sector_e;

endpackage

// ----- sv/svpwm_sector_duty.sv -----
// Seven-segment space vector PWM: sector detection and phase compare values.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid_i / in_ready_o) takes one word holding an
// alpha/beta voltage pair in signed Q1.(VOLT_WIDTH-1). The output channel
// (out_valid_o / out_ready_i) gives one word per input word: three phase
// compare values saturated to 0..compare_max and the sector, 1 to 6, or 0
// for the zero vector, in which case every compare is compare_max / 2.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes duty_gain
// (index 0) and compare_max (index 1); it is always ready, and it must be
// written only while no word is in flight, which the block does not enforce.
// A new word is accepted every cycle while the receiver takes words; the
// block is a five-stage pipeline, whose multipliers sit in the projection,
// active-time and compare stages.
// When the receiver stalls, the output register holds its word and the
// stages behind it keep filling up; empty stages close up, so input is
// still taken until every stage holds a word.
// Reset clears all stage valid bits and loads the register reset values.
`include "assert_macros.svh"

module svpwm_sector_duty #(
  parameter int unsigned VOLT_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [VOLT_WIDTH-1:0]     u_alpha_in_i,
  input  logic signed [VOLT_WIDTH-1:0]     u_beta_in_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [15:0]                      compare_a_o,
  output logic [15:0]                      compare_b_o,
  output logic [15:0]                      compare_c_o,
  output logic [2:0]                       sector_out_o
);

  // Projection, operand, active time and phase time widths.
  localparam int unsigned RW = VOLT_WIDTH + 16;
  localparam int unsigned OW = VOLT_WIDTH + 17;
  localparam int unsigned XW = VOLT_WIDTH + 32;
  localparam int unsigned PW = VOLT_WIDTH + 34;
  // Width of the partial compare sum.
  localparam int unsigned SW = VOLT_WIDTH + 29;
  // One period, at the scale of the active times.
  localparam logic signed [PW-1:0] TS = {5'b0, 1'b1, {(VOLT_WIDTH + 28){1'b0}}};

  // Configuration registers.
  logic [15:0] duty_gain_q, compare_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_gain_q   <= svpwm_pkg::DUTY_GAIN_RST;
      compare_max_q <= svpwm_pkg::COMPARE_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == svpwm_pkg::CFG_DUTY_GAIN) begin
        duty_gain_q <= cfg_data_i;
      end
      if (cfg_index_i == svpwm_pkg::CFG_COMPARE_MAX) begin
        compare_max_q <= cfg_data_i;
      end
    end
  end

  // Stage valid bits and load enables; a stage loads when empty or draining.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: the three reference projections.
  logic signed [RW-1:0] r1_d, r2_d, r3_d, r1_q, r2_q, r3_q;
  logic signed [RW-1:0] al_m, be_h;

  always_comb begin
    al_m = RW'(u_alpha_in_i) * RW'($signed({1'b0, svpwm_pkg::SQRT3_HALF_Q15}));
    be_h = RW'($signed({u_beta_in_i, 14'b0}));
    r1_d = RW'($signed({u_beta_in_i, 15'b0}));
    r2_d = al_m - be_h;
    r3_d = -al_m - be_h;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
    end
  end

  // Stage 2: sector from the projection signs, active times x and y.
  logic [2:0]              signs;
  svpwm_pkg::sector_e      sec2_d, sec2_q;
  logic signed [OW-1:0]    r1x, r2x, r3x, opx, opy;
  logic signed [16:0]      gain_s;
  logic signed [OW+16:0]   prodx, prody;
  logic signed [XW-1:0]    x2_d, y2_d, x2_q, y2_q;

  always_comb begin
    signs = {!r3_q[RW-1] && (r3_q != '0),
             !r2_q[RW-1] && (r2_q != '0),
             !r1_q[RW-1] && (r1_q != '0)};
    r1x = OW'(r1_q);
    r2x = OW'(r2_q);
    r3x = OW'(r3_q);
    case (signs)
      svpwm_pkg::SIGNS_S1: begin
        sec2_d = svpwm_pkg::SECTOR_1; opx = r2x;  opy = r1x;
      end
      svpwm_pkg::SIGNS_S2: begin
        sec2_d = svpwm_pkg::SECTOR_2; opx = -r3x; opy = -r2x;
      end
      svpwm_pkg::SIGNS_S3: begin
        sec2_d = svpwm_pkg::SECTOR_3; opx = r1x;  opy = r3x;
      end
      svpwm_pkg::SIGNS_S4: begin
        sec2_d = svpwm_pkg::SECTOR_4; opx = -r1x; opy = -r2x;
      end
      svpwm_pkg::SIGNS_S5: begin
        sec2_d = svpwm_pkg::SECTOR_5; opx = r3x;  opy = r2x;
      end
      svpwm_pkg::SIGNS_S6: begin
        sec2_d = svpwm_pkg::SECTOR_6; opx = -r3x; opy = -r1x;
      end
      default: begin
        sec2_d = svpwm_pkg::SECTOR_ZERO; opx = '0; opy = '0;
      end
    endcase
    gain_s = $signed({1'b0, duty_gain_q});
    prodx  = (OW + 17)'(opx) * (OW + 17)'(gain_s);
    prody  = (OW + 17)'(opy) * (OW + 17)'(gain_s);
    x2_d   = prodx[XW-1:0];
    y2_d   = prody[XW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sec2_q <= sec2_d;
      x2_q   <= x2_d;
      y2_q   <= y2_d;
    end
  end

  // Stage 3: doubled phase on-times, ordered by sector.
  logic signed [PW-1:0] xe, ye, t_lo, t_mid, t_hi, t_mid2;
  logic signed [PW-1:0] p3_d [3];
  logic signed [PW-1:0] p3_q [3];
  svpwm_pkg::sector_e   sec3_q;

  always_comb begin
    xe     = PW'(x2_q);
    ye     = PW'(y2_q);
    t_lo   = TS - xe - ye;
    t_mid  = TS + xe - ye;
    t_hi   = TS + xe + ye;
    t_mid2 = TS - xe + ye;
    case (sec2_q)
      svpwm_pkg::SECTOR_1: begin p3_d[0] = t_lo;   p3_d[1] = t_mid; p3_d[2] = t_hi;  end
      svpwm_pkg::SECTOR_2: begin p3_d[0] = t_mid2; p3_d[1] = t_lo;  p3_d[2] = t_hi;  end
      svpwm_pkg::SECTOR_3: begin p3_d[0] = t_hi;   p3_d[1] = t_lo;  p3_d[2] = t_mid; end
      svpwm_pkg::SECTOR_4: begin p3_d[0] = t_hi;   p3_d[1] = t_mid; p3_d[2] = t_lo;  end
      svpwm_pkg::SECTOR_5: begin p3_d[0] = t_mid;  p3_d[1] = t_hi;  p3_d[2] = t_lo;  end
      default:             begin p3_d[0] = t_lo;   p3_d[1] = t_hi;  p3_d[2] = t_mid; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sec3_q <= sec2_q;
      p3_q   <= p3_d;
    end
  end

  // Stage 4: saturation flags and the two partial products of time * max.
  logic [SW-1:0] ph4_d [3];
  logic [SW-1:0] ph4_q [3];
  logic [15:0]   pl4_d [3];
  logic [15:0]   pl4_q [3];
  logic [31:0]   lp    [3];
  logic [2:0]    zero4_d, zero4_q, max4_d, max4_q;
  svpwm_pkg::sector_e sec4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      zero4_d[i] = p3_q[i][PW-1] || (p3_q[i] == '0);
      max4_d[i]  = !p3_q[i][PW-1] && (|p3_q[i][PW-2:VOLT_WIDTH+29]);
      ph4_d[i]   = SW'(p3_q[i][VOLT_WIDTH+28:16]) * SW'(compare_max_q);
      lp[i]      = 32'(p3_q[i][15:0]) * 32'(compare_max_q);
      pl4_d[i]   = lp[i][31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      sec4_q  <= sec3_q;
      ph4_q   <= ph4_d;
      pl4_q   <= pl4_d;
      zero4_q <= zero4_d;
      max4_q  <= max4_d;
    end
  end

  // Stage 5: final compare values and the output register.
  logic [SW-1:0] csum  [3];
  logic [15:0]   cmp_d [3];
  logic [15:0]   cmp_q [3];
  svpwm_pkg::sector_e sec5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = ph4_q[i] + SW'(pl4_q[i]);
      if (sec4_q == svpwm_pkg::SECTOR_ZERO) begin
        cmp_d[i] = {1'b0, compare_max_q[15:1]};
      end else if (zero4_q[i]) begin
        cmp_d[i] = '0;
      end else if (max4_q[i]) begin
        cmp_d[i] = compare_max_q;
      end else begin
        cmp_d[i] = csum[i][VOLT_WIDTH+28:VOLT_WIDTH+13];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      sec5_q <= sec4_q;
      cmp_q  <= cmp_d;
    end
  end

  assign out_valid_o  = v5_q;
  assign compare_a_o  = cmp_q[0];
  assign compare_b_o  = cmp_q[1];
  assign compare_c_o  = cmp_q[2];
  assign sector_out_o = sec5_q;

  // Conditions watched by the assertions below.
  logic [2:0] cmp_le_max;
  logic       cmp_half_all;
  logic       zero_word;
  logic       all_full;

  assign cmp_le_max   = {compare_c_o <= compare_max_q,
                         compare_b_o <= compare_max_q,
                         compare_a_o <= compare_max_q};
  assign cmp_half_all = (compare_a_o == {1'b0, compare_max_q[15:1]}) &&
                        (compare_b_o == compare_a_o) && (compare_c_o == compare_a_o);
  assign zero_word    = out_valid_o && (sector_out_o == svpwm_pkg::SECTOR_ZERO);
  assign all_full     = v1_q && v2_q && v3_q && v4_q && v5_q;

  // Compares never exceed the configured limit.
  `ASSERT_CLK_RST(a_cmp_limit, out_valid_o |-> (&cmp_le_max), "compare above compare_max")
  // The zero vector puts every phase at half of the limit.
  `ASSERT_CLK_RST(a_zero_half, zero_word |-> cmp_half_all, "zero vector compares not at half max")
  // Input back-pressure only when every stage holds a word.
  `ASSERT_CLK(a_full_stall, !in_ready_o |-> all_full, "input stalled with an empty stage")

endmodule

// ----- tb/svpwm_sector_duty_tb.sv -----
// Self-checking testbench for the space vector PWM sector and duty block.
`timescale 1ns / 1ps

module svpwm_sector_duty_tb;

  localparam int unsigned VOLT_W = 16;
  // One PWM period and twice one period at the scale of the active times.
  localparam longint PERIOD_T = longint'(1) << (VOLT_W + 28);
  localparam longint DOUBLE_PERIOD_T = longint'(1) << (VOLT_W + 29);

  // One result word: three phase compares and the sector.
  typedef struct {
    logic [15:0]        cmp_a;
    logic [15:0]        cmp_b;
    logic [15:0]        cmp_c;
    svpwm_pkg::sector_e sector;
  } duty_word_t;

  // Computes the compare values and sector of each accepted voltage pair
  // and checks the result words against them in order.
  class duty_scoreboard;
    int unsigned errors;
    int unsigned words_checked;
    int unsigned sector_hits[7];
    logic [15:0] gain_reg;
    logic [15:0] max_reg;
    duty_word_t  pending_q[$];

    function new();
      errors = 0;
      words_checked = 0;
      foreach (sector_hits[i]) sector_hits[i] = 0;
      gain_reg = svpwm_pkg::DUTY_GAIN_RST;
      max_reg = svpwm_pkg::COMPARE_MAX_RST;
    endfunction

    function void set_reg(logic [svpwm_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        svpwm_pkg::CFG_DUTY_GAIN:   gain_reg = data;
        svpwm_pkg::CFG_COMPARE_MAX: max_reg = data;
        default: ;
      endcase
    endfunction

    // Doubled phase time to compare value: floor(p * max / 2^(VOLT_W+29)),
    // clipped to 0 below and to max at or above one full period.
    function logic [15:0] scale_compare(longint p);
      logic [63:0] v;
      logic [63:0] hi_part;
      logic [63:0] lo_part;
      logic [63:0] acc;
      if (p <= 0) return 16'd0;
      if (p >= DOUBLE_PERIOD_T) return max_reg;
      v = p;
      hi_part = v >> 16;
      lo_part = v & 64'hFFFF;
      acc = (hi_part * max_reg + ((lo_part * max_reg) >> 16)) >> (VOLT_W + 13);
      return acc[15:0];
    endfunction

    function void note_input(logic signed [15:0] alpha, logic signed [15:0] beta);
      longint al, be, r1, r2, r3, k, x, y, sq;
      longint t_lo, t_mid, t_hi, t_mid2, pa, pb, pc;
      logic [2:0] signs;
      duty_word_t w;
      al = alpha;
      be = beta;
      sq = longint'(svpwm_pkg::SQRT3_HALF_Q15);
      k = longint'(gain_reg);
      x = 0;
      y = 0;
      // Projections onto the three reference axes.
      r1 = be * 32768;
      r2 = al * sq - be * 16384;
      r3 = -(al * sq) - be * 16384;
      signs = {r3 > 0, r2 > 0, r1 > 0};
      // Sector and the two active times.
      case (signs)
        svpwm_pkg::SIGNS_S1: begin
          w.sector = svpwm_pkg::SECTOR_1; x = r2 * k;  y = r1 * k;
        end
        svpwm_pkg::SIGNS_S2: begin
          w.sector = svpwm_pkg::SECTOR_2; x = -r3 * k; y = -r2 * k;
        end
        svpwm_pkg::SIGNS_S3: begin
          w.sector = svpwm_pkg::SECTOR_3; x = r1 * k;  y = r3 * k;
        end
        svpwm_pkg::SIGNS_S4: begin
          w.sector = svpwm_pkg::SECTOR_4; x = -r1 * k; y = -r2 * k;
        end
        svpwm_pkg::SIGNS_S5: begin
          w.sector = svpwm_pkg::SECTOR_5; x = r3 * k;  y = r2 * k;
        end
        svpwm_pkg::SIGNS_S6: begin
          w.sector = svpwm_pkg::SECTOR_6; x = -r3 * k; y = -r1 * k;
        end
        default: w.sector = svpwm_pkg::SECTOR_ZERO;
      endcase
      if (w.sector == svpwm_pkg::SECTOR_ZERO) begin
        // Zero vector: all phases sit at half the compare range.
        w.cmp_a = max_reg >> 1;
        w.cmp_b = max_reg >> 1;
        w.cmp_c = max_reg >> 1;
      end else begin
        // Doubled phase on-times with the zero time split evenly.
        t_lo = PERIOD_T - x - y;
        t_mid = PERIOD_T + x - y;
        t_hi = PERIOD_T + x + y;
        t_mid2 = PERIOD_T - x + y;
        case (w.sector)
          svpwm_pkg::SECTOR_1: begin pa = t_lo;   pb = t_mid; pc = t_hi;  end
          svpwm_pkg::SECTOR_2: begin pa = t_mid2; pb = t_lo;  pc = t_hi;  end
          svpwm_pkg::SECTOR_3: begin pa = t_hi;   pb = t_lo;  pc = t_mid; end
          svpwm_pkg::SECTOR_4: begin pa = t_hi;   pb = t_mid; pc = t_lo;  end
          svpwm_pkg::SECTOR_5: begin pa = t_mid;  pb = t_hi;  pc = t_lo;  end
          default:             begin pa = t_lo;   pb = t_hi;  pc = t_mid; end
        endcase
        w.cmp_a = scale_compare(pa);
        w.cmp_b = scale_compare(pb);
        w.cmp_c = scale_compare(pc);
      end
      pending_q.push_back(w);
    endfunction

    function void check_result(logic [15:0] got_a, logic [15:0] got_b,
                               logic [15:0] got_c, logic [2:0] got_sector);
      duty_word_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word a=%0d b=%0d c=%0d sector=%0d", $time,
                 got_a, got_b, got_c, got_sector);
        return;
      end
      want = pending_q.pop_front();
      words_checked++;
      sector_hits[want.sector]++;
      if (got_a !== want.cmp_a) begin
        errors++;
        $display("%0t: compare_a expected %0d, got %0d", $time, want.cmp_a, got_a);
      end
      if (got_b !== want.cmp_b) begin
        errors++;
        $display("%0t: compare_b expected %0d, got %0d", $time, want.cmp_b, got_b);
      end
      if (got_c !== want.cmp_c) begin
        errors++;
        $display("%0t: compare_c expected %0d, got %0d", $time, want.cmp_c, got_c);
      end
      if (got_sector !== want.sector) begin
        errors++;
        $display("%0t: sector expected %0d, got %0d", $time, want.sector, got_sector);
      end
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [svpwm_pkg::CFG_IDX_W-1:0]     cfg_index_i = svpwm_pkg::CFG_DUTY_GAIN;
  logic [15:0]                         cfg_data_i = 16'd0;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  logic signed [VOLT_W-1:0]            u_alpha_in_i = '0;
  logic signed [VOLT_W-1:0]            u_beta_in_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic [15:0]                         compare_a_o;
  logic [15:0]                         compare_b_o;
  logic [15:0]                         compare_c_o;
  logic [2:0]                          sector_out_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned reg_settings = 1;

  duty_scoreboard board = new();

  svpwm_sector_duty #(
    .VOLT_WIDTH(VOLT_W)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .u_alpha_in_i(u_alpha_in_i),
    .u_beta_in_i(u_beta_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .compare_a_o(compare_a_o),
    .compare_b_o(compare_b_o),
    .compare_c_o(compare_c_o),
    .sector_out_o(sector_out_o)
  );

  // Clock with a 4 ns period.
  always #2 clk_i = ~clk_i;

  // Result side: check every accepted word and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(compare_a_o, compare_b_o, compare_c_o, sector_out_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one voltage pair, after an optional random gap, until it is taken.
  task automatic drive_sample(input logic signed [15:0] alpha,
                              input logic signed [15:0] beta);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    u_alpha_in_i <= alpha;
    u_beta_in_i <= beta;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(alpha, beta);
  endtask

  // Writes both registers back to back; the block is idle at this point.
  task automatic write_regs(input logic [15:0] gain, input logic [15:0] cmax);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= svpwm_pkg::CFG_DUTY_GAIN;
    cfg_data_i <= gain;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(svpwm_pkg::CFG_DUTY_GAIN, gain);
    cfg_index_i <= svpwm_pkg::CFG_COMPARE_MAX;
    cfg_data_i <= cmax;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(svpwm_pkg::CFG_COMPARE_MAX, cmax);
    cfg_valid_i <= 1'b0;
    reg_settings++;
  endtask

  // Mostly full-range values, with zero, the extremes and small magnitudes.
  function automatic logic [15:0] pick_volt();
    case ($urandom_range(15))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'h7FFF;
      3, 4, 5: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Corners: zero vector, full-scale pairs, axis points and one per sector.
  task automatic run_corners();
    drive_sample(16'sh0000, 16'sh0000);
    drive_sample(16'sh7FFF, 16'sh0000);
    drive_sample(16'sh8000, 16'sh0000);
    drive_sample(16'sh0000, 16'sh7FFF);
    drive_sample(16'sh0000, 16'sh8000);
    drive_sample(16'sh7FFF, 16'sh7FFF);
    drive_sample(16'sh8000, 16'sh8000);
    drive_sample(16'sh7FFF, 16'sh8000);
    drive_sample(16'sh8000, 16'sh7FFF);
    drive_sample(16'sh0001, 16'sh0000);
    drive_sample(16'shFFFF, 16'sh0000);
    drive_sample(16'sh0000, 16'sh0001);
    drive_sample(16'sh0000, 16'shFFFF);
    drive_sample(16'sh4000, 16'sh1000);
    drive_sample(16'sh03E8, 16'sh4000);
    drive_sample(16'shC000, 16'sh1000);
    drive_sample(16'shC000, 16'shF000);
    drive_sample(16'sh03E8, 16'shC000);
    drive_sample(16'sh4000, 16'shF000);
    drive_sample(16'sh0100, 16'sh0080);
  endtask

  // One register setting: corners, then random pairs, then wait for all words.
  task automatic run_phase(input bit do_write, input logic [15:0] gain,
                           input logic [15:0] cmax, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned n_random);
    if (do_write) write_regs(gain, cmax);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    run_corners();
    repeat (n_random) drive_sample(pick_volt(), pick_volt());
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Main sequence.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_phase(1'b0, svpwm_pkg::DUTY_GAIN_RST, svpwm_pkg::COMPARE_MAX_RST, 0, 0, 100);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 88, 0, 100);
    run_phase(1'b1, 16'h0000, 16'h0001, 0, 88, 100);
    run_phase(1'b1, 16'h0001, 16'hFFFF, 26, 26, 100);
    // A compare maximum of zero forces every compare to zero.
    run_phase(1'b1, 16'd28378, 16'h0000, 0, 0, 60);
    run_phase(1'b1, 16'($urandom), 16'($urandom_range(1, 65535)), 26, 26, 100);
    run_phase(1'b1, 16'($urandom), 16'($urandom_range(1, 65535)), 0, 0, 60);
    // Let the pipeline run dry so that any stray word shows up.
    repeat (20) @(posedge clk_i);
    $display("Checked %0d words (corner and random pairs) under %0d register settings.",
             board.words_checked, reg_settings);
    $display("Words per sector 0..6: %0d %0d %0d %0d %0d %0d %0d",
             board.sector_hits[0], board.sector_hits[1], board.sector_hits[2],
             board.sector_hits[3], board.sector_hits[4], board.sector_hits[5],
             board.sector_hits[6]);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_600_000;
    $display("Timeout with %0d words still pending.", board.pending_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/svpwm_pkg.sv
sv/svpwm_sector_duty.sv
tb/svpwm_sector_duty_tb.sv
